>>> hdl/ssdfb_pkg.sv
// ----------------------------------------------------------------------------
// Seven-segment frame builder package
// Command codes, wire byte constants, queue entry type and the segment decoder
// shared by the front end, the queue and the byte sequencer.
// ----------------------------------------------------------------------------
package ssdfb_pkg;

    // Input kinds as they arrive on the request channel.
    localparam logic [2:0] KIND_CHECKED = 3'd0;
    localparam logic [2:0] KIND_MODULO  = 3'd1;
    localparam logic [2:0] KIND_DECIMAL = 3'd2;
    localparam logic [2:0] KIND_RAW     = 3'd3;
    localparam logic [2:0] KIND_INIT    = 3'd4;
    localparam logic [2:0] KIND_ON      = 3'd5;
    localparam logic [2:0] KIND_OFF     = 3'd6;

    // Bytes sent to the display driver.
    localparam logic [7:0] ADDR_FIXED_BASE = 8'hC0;
    localparam logic [7:0] DATA_CMD_FIXED  = 8'h44;
    localparam logic [7:0] DISP_ON_CMD     = 8'h8F;
    localparam logic [7:0] DISP_OFF_CMD    = 8'h80;
    localparam logic [7:0] SEG_DOT         = 8'h80;

    // Reciprocal of ten for a 16-bit dividend: q = (v * RECIP_TEN) >> RECIP_SHIFT.
    localparam logic [15:0] RECIP_TEN   = 16'hCCCD;
    localparam int          RECIP_SHIFT = 19;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CMD_DIGITS,
        CMD_RAW,
        CMD_INIT,
        CMD_ON,
        CMD_OFF
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic        dot;
        logic [15:0] value;
        logic [3:0]  grid;
        logic [7:0]  segs;
    } qentry_t;

    typedef struct packed {
        logic not_full;
        logic not_empty;
    } qstat_t;

    // Common-cathode segment pattern for one decimal digit.
    function automatic logic [7:0] seg_decode(input logic [3:0] digit);
        logic [7:0] pattern;
        unique case (digit)
            4'd0:    pattern = 8'h3F;
            4'd1:    pattern = 8'h06;
            4'd2:    pattern = 8'h5B;
            4'd3:    pattern = 8'h4F;
            4'd4:    pattern = 8'h66;
            4'd5:    pattern = 8'h6D;
            4'd6:    pattern = 8'h7D;
            4'd7:    pattern = 8'h07;
            4'd8:    pattern = 8'h7F;
            4'd9:    pattern = 8'h6F;
            default: pattern = 8'h00;
        endcase
        return pattern;
    endfunction

endpackage

>>> hdl/ssdfb_front.sv
// ----------------------------------------------------------------------------
// Command front end
// Accepts requests, drops those that produce no bytes and turns the rest into
// queue entries for the byte sequencer.
// ----------------------------------------------------------------------------
module ssdfb_front #(
    parameter int NUM_DIGITS = 4
) (
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [2:0]         kind,
    input  logic [15:0]        value,
    input  logic [7:0]         grid,
    input  logic [7:0]         segs,
    input  ssdfb_pkg::qstat_t  qstat,
    output logic               q_wr_en,
    output ssdfb_pkg::qentry_t q_wr_data
);
    import ssdfb_pkg::*;

    localparam int unsigned LIMIT = 10 ** NUM_DIGITS;

    logic keep;

    always_comb begin
        keep            = 1'b1;
        q_wr_data.cmd   = CMD_DIGITS;
        q_wr_data.dot   = 1'b0;
        q_wr_data.value = value;
        q_wr_data.grid  = grid[3:0];
        q_wr_data.segs  = segs;
        unique case (kind)
            KIND_CHECKED: keep = (32'(value) < LIMIT);
            KIND_MODULO:  keep = 1'b1;
            KIND_DECIMAL: q_wr_data.dot = 1'b1;
            KIND_RAW: begin
                q_wr_data.cmd = CMD_RAW;
                keep          = (grid[7:4] == 4'd0);
            end
            KIND_INIT:    q_wr_data.cmd = CMD_INIT;
            KIND_ON:      q_wr_data.cmd = CMD_ON;
            KIND_OFF:     q_wr_data.cmd = CMD_OFF;
            default:      keep = 1'b0;
        endcase
    end

    // Dropped requests are still taken, they just never reach the queue.
    assign s_tready = qstat.not_full;
    assign q_wr_en  = s_tvalid && qstat.not_full && keep;

endmodule

>>> hdl/ssdfb_queue.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry register queue between the front end and the byte sequencer.
// ----------------------------------------------------------------------------
module ssdfb_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_en,
    input  ssdfb_pkg::qentry_t wr_data,
    input  logic               rd_en,
    output ssdfb_pkg::qentry_t rd_data,
    output ssdfb_pkg::qstat_t  stat
);
    import ssdfb_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    qentry_t            mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wptr_reg, wptr_next;
    logic [PTR_W-1:0]   rptr_reg, rptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (wr_en) begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (rd_en) begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (wr_en && !rd_en) begin
            count_next = count_reg + 1'b1;
        end else if (rd_en && !wr_en) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

    assign rd_data        = mem_reg[rptr_reg];
    assign stat.not_full  = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign stat.not_empty = (count_reg != '0);

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

endmodule

>>> hdl/ssdfb_back.sv
// ----------------------------------------------------------------------------
// Byte sequencer
// Takes queue entries and emits their wire bytes one per cycle, unless the output
// is stalled, into an output register, splitting numbers into decimal digits units first.
// ----------------------------------------------------------------------------
module ssdfb_back #(
    parameter int NUM_DIGITS = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  ssdfb_pkg::qstat_t  qstat,
    input  ssdfb_pkg::qentry_t head,
    output logic               q_rd_en,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);
    import ssdfb_pkg::*;

    localparam int         STEP_W   = $clog2(2 * NUM_DIGITS);
    localparam logic [3:0] TOP_GRID = 4'(NUM_DIGITS - 1);

    logic              active_reg, active_next;
    logic [STEP_W-1:0] step_reg, step_next;
    cmd_t              cmd_reg, cmd_next;
    logic              dot_reg, dot_next;
    logic [15:0]       value_reg, value_next;
    logic [3:0]        digit_reg, digit_next;
    logic [3:0]        grid_reg, grid_next;
    logic [7:0]        segs_reg, segs_next;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_byte_reg, out_byte_next;
    logic              out_start_reg, out_start_next;
    logic              out_end_reg, out_end_next;
    logic              out_last_reg, out_last_next;

    cmd_t              cur_cmd;
    logic              cur_dot;
    logic [15:0]       cur_value;
    logic [3:0]        cur_grid;
    logic [7:0]        cur_segs;
    logic [STEP_W-1:0] cur_step;
    logic [STEP_W-1:0] last_step;
    logic              is_last;
    logic              advance;
    logic              emit;

    logic [31:0]       prod;
    logic [12:0]       quot;
    logic [15:0]       ten_q;
    logic [15:0]       rem;

    logic [7:0]        gen_byte;
    logic              gen_start;
    logic              gen_end;

    // While idle the head of the queue drives the first byte directly.
    assign cur_cmd   = active_reg ? cmd_reg   : head.cmd;
    assign cur_dot   = active_reg ? dot_reg   : head.dot;
    assign cur_value = active_reg ? value_reg : head.value;
    assign cur_grid  = active_reg ? grid_reg  : head.grid;
    assign cur_segs  = active_reg ? segs_reg  : head.segs;
    assign cur_step  = active_reg ? step_reg  : '0;

    // One digit per address byte: quotient by reciprocal, remainder by shift-add.
    assign prod  = cur_value * RECIP_TEN;
    assign quot  = prod[31:RECIP_SHIFT];
    assign ten_q = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
    assign rem   = cur_value - ten_q;

    assign advance = !out_valid_reg || m_tready;
    assign emit    = advance && (active_reg || qstat.not_empty);
    assign q_rd_en = emit && !active_reg;

    always_comb begin
        unique case (cur_cmd)
            CMD_DIGITS:      last_step = STEP_W'(2 * NUM_DIGITS - 1);
            CMD_RAW,
            CMD_INIT:        last_step = STEP_W'(1);
            CMD_ON,
            CMD_OFF:         last_step = '0;
            default:         last_step = '0;
        endcase
    end

    assign is_last = (cur_step == last_step);

    // Byte generator.
    always_comb begin
        gen_byte  = 8'h00;
        gen_start = 1'b1;
        gen_end   = 1'b1;
        unique case (cur_cmd)
            CMD_DIGITS: begin
                if (!cur_step[0]) begin
                    gen_byte = ADDR_FIXED_BASE | {4'b0000, TOP_GRID - 4'(cur_step >> 1)};
                    gen_end  = 1'b0;
                end else begin
                    gen_byte  = seg_decode(digit_reg);
                    gen_start = 1'b0;
                    // The hundreds digit holds the units of the real number.
                    if (cur_dot && (NUM_DIGITS >= 3) && (cur_step == STEP_W'(5))) begin
                        gen_byte = gen_byte | SEG_DOT;
                    end
                end
            end
            CMD_RAW: begin
                if (!cur_step[0]) begin
                    gen_byte = ADDR_FIXED_BASE | {4'b0000, cur_grid};
                    gen_end  = 1'b0;
                end else begin
                    gen_byte  = cur_segs;
                    gen_start = 1'b0;
                end
            end
            CMD_INIT: gen_byte = cur_step[0] ? DISP_ON_CMD : DATA_CMD_FIXED;
            CMD_ON:   gen_byte = DISP_ON_CMD;
            CMD_OFF:  gen_byte = DISP_OFF_CMD;
            default:  gen_byte = 8'h00;
        endcase
    end

    // Sequencer next state.
    always_comb begin
        active_next = active_reg;
        step_next   = step_reg;
        cmd_next    = cmd_reg;
        dot_next    = dot_reg;
        value_next  = value_reg;
        digit_next  = digit_reg;
        grid_next   = grid_reg;
        segs_next   = segs_reg;
        if (emit) begin
            active_next = !is_last;
            step_next   = cur_step + 1'b1;
            if (!active_reg) begin
                cmd_next  = head.cmd;
                dot_next  = head.dot;
                grid_next = head.grid;
                segs_next = head.segs;
            end
            if (!cur_step[0]) begin
                value_next = 16'(quot);
                digit_next = rem[3:0];
            end
        end
    end

    // Output register next state.
    always_comb begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_start_next = out_start_reg;
        out_end_next   = out_end_reg;
        out_last_next  = out_last_reg;
        if (advance) begin
            out_valid_next = emit;
            if (emit) begin
                out_byte_next  = gen_byte;
                out_start_next = gen_start;
                out_end_next   = gen_end;
                out_last_next  = is_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg       <= cmd_next;
        dot_reg       <= dot_next;
        value_reg     <= value_next;
        digit_reg     <= digit_next;
        grid_reg      <= grid_next;
        segs_reg      <= segs_next;
        out_byte_reg  <= out_byte_next;
        out_start_reg <= out_start_next;
        out_end_reg   <= out_end_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_end_reg, out_start_reg};
    assign m_tlast  = out_last_reg;

    a_active_step: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg |-> (step_reg != '0))
        else $error("sequencer active on its first step");

    a_frame_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[0] || m_tuser[1]))
        else $error("byte outside any frame");

    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && is_last) |=> !active_reg)
        else $error("sequencer still active after final byte");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_rd_en |-> qstat.not_empty)
        else $error("pop from empty queue");

endmodule

>>> hdl/seven_segment_display_frame_builder.sv
// ----------------------------------------------------------------------------
// Seven-segment display frame builder
// Turns display commands into the byte stream for a 16-grid serial LED driver.
// ----------------------------------------------------------------------------
// The first byte of a request passes through the queue and the output register before it
// appears on m_tvalid. A number request yields 2*NUM_DIGITS bytes, raw write and init two,
// display on and off one; the sequencer emits one byte per cycle while m_tready allows.
// Requests that produce no bytes are taken and leave no trace.
// Reset (aresetn low at a clock edge) empties the queue and the output register.
module seven_segment_display_frame_builder #(
    parameter int NUM_DIGITS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // value[15:0], grid[23:16], segments[31:24]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // wire_byte[7:0]
    output logic [1:0]  m_tuser,   // frame_start[0], frame_end[1]
    output logic        m_tlast
);
    import ssdfb_pkg::*;

    qstat_t  qstat;
    qentry_t q_wr_data;
    qentry_t q_head;
    logic    q_wr_en;
    logic    q_rd_en;

    ssdfb_front #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .value    (s_tdata[15:0]),
        .grid     (s_tdata[23:16]),
        .segs     (s_tdata[31:24]),
        .qstat    (qstat),
        .q_wr_en  (q_wr_en),
        .q_wr_data(q_wr_data)
    );

    ssdfb_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .wr_en  (q_wr_en),
        .wr_data(q_wr_data),
        .rd_en  (q_rd_en),
        .rd_data(q_head),
        .stat   (qstat)
    );

    ssdfb_back #(
        .NUM_DIGITS(NUM_DIGITS)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .qstat   (qstat),
        .head    (q_head),
        .q_rd_en (q_rd_en),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// Seven-segment display frame builder testbench
// Sends display commands on the request channel and checks every wire byte,
// with its frame flags and last marker, against a predicted byte stream.
// Directed corner cases come first, then random commands under three idling
// patterns and one long output stall.
// ----------------------------------------------------------------------------
module testbench;
    import ssdfb_pkg::*;

    localparam int NUM_DIGITS   = 4;
    localparam int DIGIT_LIMIT  = 10 ** NUM_DIGITS;
    localparam int RANDOM_PER_PHASE = 100;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int TIMEOUT_TU   = 2_000_000;

    // Code 7 has no meaning and must leave no trace on the output.
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    localparam logic [7:0] DIGIT_GLYPH [10] = '{
        8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
    };

    typedef struct {
        logic [7:0] data;
        logic       start;
        logic       stop;
        logic       last;
    } wire_byte_t;

    class display_scoreboard;
        wire_byte_t expected_bytes[$];
        int         mismatches;
        int         requests_seen;
        int         bytes_checked;

        function void push_byte(logic [7:0] data, logic start, logic stop);
            wire_byte_t b;
            b.data  = data;
            b.start = start;
            b.stop  = stop;
            b.last  = 1'b0;
            expected_bytes.push_back(b);
        endfunction

        function void push_grid_frame(logic [3:0] grid, logic [7:0] segs);
            push_byte(ADDR_FIXED_BASE | {4'h0, grid}, 1'b1, 1'b0);
            push_byte(segs, 1'b0, 1'b1);
        endfunction

        // Units digit goes out first, on the highest grid.
        function void push_number(int unsigned v, bit dot);
            logic [7:0] segs;
            for (int i = 0; i < NUM_DIGITS; i++) begin
                segs = DIGIT_GLYPH[v % 10];
                if (dot && i == 2)
                    segs = segs | SEG_DOT;
                push_grid_frame(4'(NUM_DIGITS - 1 - i), segs);
                v = v / 10;
            end
        endfunction

        function void note_request(logic [2:0] kind, logic [15:0] value,
                                   logic [7:0] grid, logic [7:0] segs);
            int queued_before;
            queued_before = expected_bytes.size();
            requests_seen++;
            case (kind)
                KIND_CHECKED: begin
                    if (value < DIGIT_LIMIT)
                        push_number(value, 1'b0);
                end
                KIND_MODULO:  push_number(value, 1'b0);
                KIND_DECIMAL: push_number(value, NUM_DIGITS >= 3);
                KIND_RAW: begin
                    if (grid <= 8'd15)
                        push_grid_frame(grid[3:0], segs);
                end
                KIND_INIT: begin
                    push_byte(DATA_CMD_FIXED, 1'b1, 1'b1);
                    push_byte(DISP_ON_CMD, 1'b1, 1'b1);
                end
                KIND_ON:  push_byte(DISP_ON_CMD, 1'b1, 1'b1);
                KIND_OFF: push_byte(DISP_OFF_CMD, 1'b1, 1'b1);
                default: ;
            endcase
            if (expected_bytes.size() > queued_before)
                expected_bytes[expected_bytes.size() - 1].last = 1'b1;
        endfunction

        function void check_byte(logic [7:0] data, logic start, logic stop, logic last);
            wire_byte_t exp_b;
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected byte %02h start=%0b end=%0b last=%0b",
                             $realtime, data, start, stop, last);
                return;
            end
            exp_b = expected_bytes.pop_front();
            if (data !== exp_b.data || start !== exp_b.start ||
                stop !== exp_b.stop || last !== exp_b.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: byte mismatch, expected %02h start=%0b end=%0b last=%0b,",
                              " got %02h start=%0b end=%0b last=%0b"}, $realtime,
                             exp_b.data, exp_b.start, exp_b.stop, exp_b.last,
                             data, start, stop, last);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;   // value[15:0], grid[23:16], segments[31:24]
    logic [2:0]  s_tuser;   // kind[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // wire_byte[7:0]
    logic [1:0]  m_tuser;   // frame_start[0], frame_end[1]
    logic        m_tlast;

    display_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    bit hold_armed  = 1'b0;

    seven_segment_display_frame_builder #(
        .NUM_DIGITS(NUM_DIGITS)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Both channels are observed at the rising edge, before the block updates.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_request(s_tuser, s_tdata[15:0], s_tdata[23:16], s_tdata[31:24]);
        if (aresetn && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
    end

    // Receiver: random back-pressure, plus one long hold when the sender asks for it.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_armed) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_armed = 1'b0;
            end
            m_tready = ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        #(TIMEOUT_TU);
        $display("timeout with %0d bytes still expected", sb.pending());
        $display("testbench: FAIL");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input logic [2:0] kind, input logic [15:0] value,
                                input logic [7:0] grid, input logic [7:0] segs);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {segs, grid, value};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_random_request(output bit yields_bytes);
        logic [2:0]  kind;
        logic [15:0] value;
        logic [7:0]  grid;
        logic [7:0]  segs;
        int          pick;
        pick  = $urandom_range(99);
        kind  = pick < 25 ? KIND_CHECKED :
                pick < 45 ? KIND_MODULO  :
                pick < 65 ? KIND_DECIMAL :
                pick < 80 ? KIND_RAW     :
                pick < 87 ? KIND_INIT    :
                pick < 92 ? KIND_ON      :
                pick < 97 ? KIND_OFF     : KIND_UNUSED;
        value = $urandom_range(1) ? 16'($urandom_range(DIGIT_LIMIT - 1))
                                  : 16'($urandom_range(65535));
        grid  = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 16))
                                         : 8'($urandom_range(15));
        segs  = 8'($urandom_range(255));
        send_request(kind, value, grid, segs);
        yields_bytes = !(kind == KIND_UNUSED ||
                         (kind == KIND_RAW && grid > 8'd15) ||
                         (kind == KIND_CHECKED && value >= DIGIT_LIMIT));
    endtask

    initial begin
        bit yields_bytes;
        bit hold_done;
        int produced;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_CHECKED;
        aresetn   = 1'b0;
        hold_done = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        tx_idle_pct = 25;
        rx_idle_pct = 84;

        // Range limits of each number kind, the dot position and the ignored cases.
        send_request(KIND_CHECKED, 16'd0,     8'd0,   8'd0);
        send_request(KIND_CHECKED, 16'd9999,  8'd0,   8'd0);
        send_request(KIND_CHECKED, 16'd10000, 8'd0,   8'd0);
        send_request(KIND_CHECKED, 16'hFFFF,  8'hFF,  8'hFF);
        send_request(KIND_MODULO,  16'd0,     8'd0,   8'd0);
        send_request(KIND_MODULO,  16'd9999,  8'd0,   8'd0);
        send_request(KIND_MODULO,  16'd10000, 8'd0,   8'd0);
        send_request(KIND_MODULO,  16'd12345, 8'd0,   8'd0);
        send_request(KIND_MODULO,  16'hFFFF,  8'hFF,  8'hFF);
        send_request(KIND_DECIMAL, 16'd0,     8'd0,   8'd0);
        send_request(KIND_DECIMAL, 16'd1234,  8'd0,   8'd0);
        send_request(KIND_DECIMAL, 16'd99,    8'd0,   8'd0);
        send_request(KIND_DECIMAL, 16'hFFFF,  8'hFF,  8'hFF);
        send_request(KIND_RAW,     16'd0,     8'd0,   8'h00);
        send_request(KIND_RAW,     16'hFFFF,  8'd15,  8'hFF);
        send_request(KIND_RAW,     16'd0,     8'd7,   8'hA5);
        send_request(KIND_RAW,     16'd0,     8'd16,  8'h5A);
        send_request(KIND_RAW,     16'd0,     8'hFF,  8'hFF);
        send_request(KIND_INIT,    16'd0,     8'd0,   8'd0);
        send_request(KIND_ON,      16'd0,     8'd0,   8'd0);
        send_request(KIND_OFF,     16'd0,     8'd0,   8'd0);
        send_request(KIND_UNUSED,  16'hFFFF,  8'hFF,  8'hFF);
        send_request(KIND_UNUSED,  16'd0,     8'd0,   8'd0);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 25 : (phase == 1) ? 84 : 0;
            rx_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 25 : 0;
            produced = 0;
            while (produced < RANDOM_PER_PHASE) begin
                send_random_request(yields_bytes);
                if (yields_bytes)
                    produced++;
                // The sender keeps offering requests while the output is held off.
                if (phase == 2 && produced == 40 && !hold_done) begin
                    hold_armed = 1'b1;
                    hold_done  = 1'b1;
                end
            end
        end
        s_tvalid = 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d requests of all command kinds and %0d wire bytes,",
                 sb.requests_seen, sb.bytes_checked);
        $display("under sender and receiver idling and one long output stall; %0d mismatches.",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
